[design/water_ripple_stencil_assert.svh]
// Assertion macros for the water ripple stencil RTL.
// Included by the top level; depends on nothing else.
`ifndef WATER_RIPPLE_STENCIL_ASSERT_SVH
`define WATER_RIPPLE_STENCIL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/wrs_pkg.sv]
// Package for the water ripple stencil: grid geometry, action codes and
// the command and status words between controller and datapath. No dependencies.
package wrs_pkg;

   localparam int GRID_SIDE     = 32;
   localparam int CELL_W        = 8;
   localparam int LANE_CNT      = 8;
   localparam int LANE_SEL_W    = $clog2(LANE_CNT);
   localparam int WORD_W        = CELL_W * LANE_CNT;
   localparam int WORDS_PER_ROW = GRID_SIDE / LANE_CNT;
   localparam int WORD_SEL_W    = $clog2(WORDS_PER_ROW);
   localparam int ROW_W         = $clog2(GRID_SIDE);
   localparam int COL_W         = $clog2(GRID_SIDE);
   localparam int MAP_WORDS     = GRID_SIDE * WORDS_PER_ROW;
   localparam int ADDR_W        = $clog2(MAP_WORDS);
   localparam int ROW_BITS      = WORD_W * WORDS_PER_ROW;
   localparam int WIN_ROWS      = 3;
   localparam int ROWOFF_W      = 2;
   localparam int LOAD_CNT      = WIN_ROWS * WORDS_PER_ROW;
   localparam int LOAD_IDX_W    = ROWOFF_W + WORD_SEL_W;
   localparam int SUM_W         = CELL_W + 3;
   localparam int SHIFT_W       = 3;
   localparam int ACTION_W      = 2;

   localparam logic [SHIFT_W-1:0] DAMPING_RESET = 3'd2;

   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FRAME = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

   typedef struct packed {
      logic                  latch_req;
      logic                  clear_wr;
      logic [ADDR_W-1:0]     clear_addr;
      logic                  rmw_rd;
      logic                  rmw_wr;
      logic                  rd_rd;
      logic                  ld_issue;
      logic [ROWOFF_W-1:0]   ld_rowoff;
      logic                  calc_wr;
      logic [WORD_SEL_W-1:0] word;
      logic [ROW_W-1:0]      frame_row;
      logic                  swap;
      logic                  load_rsp;
   } wrs_cmd_type;

   typedef struct packed {
      logic                rsp_free;
      logic [ACTION_W-1:0] action;
   } wrs_sts_type;

endpackage

[design/water_ripple_stencil.sv]
// Top level of the water ripple stencil: controller plus datapath.
// Depends on wrs_pkg, wrs_ctrl, wrs_datapath and the assertion macro header.
//
//   Channel  Direction  Handshake            Word
//   req      in         req_valid/req_stall  action, row, column, amount
//   rsp      out        rsp_valid/rsp_stall  read_data, frame_done
//   csr      in         csr_wr_en            damping_shift (csr_wr_data)
//
// Each map is stored as 64-bit words of eight cells, four words per row.
// Add and set read, merge and write one word; a read fetches one word. A frame
// advance walks the interior rows: per row the current map's single read port
// loads 12 window words and the previous map's port four words of the row, then
// four lanes-of-eight words are written back. After reset a clearing pass over
// 128 words zeroes both maps while requests stall. A stalled result waits in the
// output register; the next item is taken meanwhile and parks until it drains.
`include "water_ripple_stencil_assert.svh"

module water_ripple_stencil import wrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SHIFT_W-1:0]  csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [ROW_W-1:0]    req_row,
   input  logic [COL_W-1:0]    req_column,
   input  logic [CELL_W-1:0]   req_amount,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_read_data,
   output logic                rsp_frame_done
);

   wrs_cmd_type cmd;
   wrs_sts_type sts;
   logic        req_accept;

   assign req_accept = req_valid && !req_stall;

   // The controller owns sequencing; the datapath owns all storage.
   wrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wrs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_amount     (req_amount),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_frame_done (rsp_frame_done)
   );

   // A result is never loaded while an earlier one is still held.
   `WRS_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.load_rsp, sts.rsp_free, "result overwritten")
   // An accepted request passes the access state before its result is loaded.
   `WRS_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_accept, !cmd.load_rsp, "result too early")
   // The clearing pass keeps the request side stalled.
   `WRS_ASSERT_SAME(a_clear_stalls, clock, reset, cmd.clear_wr, req_stall, "accept during clear")

endmodule

[design/wrs_ram.sv]
// Generic simple dual port RAM: one write port, one registered read port.
// Standalone; no package needed.
module wrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/wrs_ctrl.sv]
// Controller for the water ripple stencil: clearing pass, item sequencing
// and the frame walk over rows and words. Depends on wrs_pkg.
module wrs_ctrl import wrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  wrs_sts_type sts,
   output wrs_cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ACCESS = 3'd2;
   localparam logic [2:0] ST_MODIFY = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_CALC   = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clear_ff, clear_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [LOAD_IDX_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
         row_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      row_in        = row_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.clear_addr = clear_ff;
      cmd.frame_row = row_ff;
      cmd.word      = cnt_ff[WORD_SEL_W-1:0];
      cmd.ld_rowoff = cnt_ff[LOAD_IDX_W-1:WORD_SEL_W];
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            clear_in = clear_ff + ADDR_W'(1);
            if (clear_ff == ADDR_W'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            case (sts.action)
               ACT_ADD, ACT_SET: begin
                  cmd.rmw_rd = 1'b1;
                  state_in = ST_MODIFY;
               end
               ACT_READ: begin
                  cmd.rd_rd = 1'b1;
                  state_in = ST_RESULT;
               end
               default: begin
                  row_in   = ROW_W'(1);
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end
            endcase
         end
         ST_MODIFY: begin
            cmd.rmw_wr = 1'b1;
            state_in = ST_RESULT;
         end
         ST_LOAD: begin
            cmd.ld_issue = 1'b1;
            if (cnt_ff == LOAD_IDX_W'(LOAD_CNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + LOAD_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc_wr = 1'b1;
            if (cnt_ff[WORD_SEL_W-1:0] == WORD_SEL_W'(WORDS_PER_ROW - 1)) begin
               cnt_in = '0;
               if (row_ff == ROW_W'(GRID_SIDE - 2)) begin
                  cmd.swap = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  state_in = ST_LOAD;
               end
            end else begin
               cnt_in = cnt_ff + LOAD_IDX_W'(1);
            end
         end
         ST_RESULT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/wrs_datapath.sv]
// Datapath for the water ripple stencil: two map RAMs, the row window,
// eight stencil lanes, the damping register and the result register. Uses wrs_pkg.
module wrs_datapath import wrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [ROW_W-1:0]    req_row,
   input  logic [COL_W-1:0]    req_column,
   input  logic [CELL_W-1:0]   req_amount,
   input  logic                csr_wr_en,
   input  logic [SHIFT_W-1:0]  csr_wr_data,
   input  wrs_cmd_type         cmd,
   output wrs_sts_type         sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_read_data,
   output logic                rsp_frame_done
);

   logic [ACTION_W-1:0]   act_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [COL_W-1:0]      col_ff;
   logic [CELL_W-1:0]     amt_ff;
   logic                  cur_is_b_ff;
   logic [SHIFT_W-1:0]    damp_ff;
   logic                  cap_valid_ff;
   logic [ROWOFF_W-1:0]   cap_rowoff_ff;
   logic [WORD_SEL_W-1:0] cap_word_ff;
   logic [ROW_BITS-1:0]   win_ff [WIN_ROWS];
   logic [ROW_BITS-1:0]   prev_row_ff;
   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     rsp_data_ff;
   logic                  rsp_done_ff;

   logic                  cur_rd_en, prev_rd_en, cur_wr_en, prev_wr_en;
   logic [ADDR_W-1:0]     cur_rd_addr, prev_rd_addr, cur_wr_addr, prev_wr_addr;
   logic [WORD_W-1:0]     cur_wr_data, prev_wr_data, cur_q, prev_q;
   logic [ROW_W-1:0]      ld_row;
   logic                  a_wr_en, b_wr_en, a_rd_en, b_rd_en;
   logic [ADDR_W-1:0]     a_wr_addr, b_wr_addr, a_rd_addr, b_rd_addr;
   logic [WORD_W-1:0]     a_wr_data, b_wr_data, a_q, b_q;
   logic [CELL_W-1:0]     old_byte, new_byte;
   logic [COL_W-1:0]      lane_c, lane_l, lane_r;
   logic [SUM_W-1:0]      lane_sum;
   logic [CELL_W-1:0]     lane_old;

   function automatic logic [CELL_W-1:0] cell_next(input logic [SUM_W-1:0]   s,
                                                   input logic [CELL_W-1:0]  old,
                                                   input logic [SHIFT_W-1:0] ds);
      logic [CELL_W:0]          avg;
      logic [CELL_W:0]          loss;
      logic signed [CELL_W+1:0] diff;
      avg  = s[SUM_W-1:2];
      loss = {1'b0, old} + ({1'b0, old} >> ds);
      diff = signed'({1'b0, avg}) - signed'({1'b0, loss});
      if (diff[CELL_W+1]) begin
         return '0;
      end else if (diff[CELL_W]) begin
         return '1;
      end
      return diff[CELL_W-1:0];
   endfunction

   // Request, configuration and map select registers.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         act_ff <= req_action;
         row_ff <= req_row;
         col_ff <= req_column;
         amt_ff <= req_amount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_is_b_ff  <= 1'b0;
         damp_ff      <= DAMPING_RESET;
         cap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.swap) begin
            cur_is_b_ff <= ~cur_is_b_ff;
         end
         if (csr_wr_en) begin
            damp_ff <= csr_wr_data;
         end
         cap_valid_ff <= cmd.ld_issue;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign sts.action   = act_ff;

   // Window capture in the cycle after each load read.
   always_ff @(posedge clock) begin
      cap_rowoff_ff <= cmd.ld_rowoff;
      cap_word_ff   <= cmd.word;
      if (cap_valid_ff) begin
         win_ff[cap_rowoff_ff][cap_word_ff*WORD_W +: WORD_W] <= cur_q;
         if (cap_rowoff_ff == '0) begin
            prev_row_ff[cap_word_ff*WORD_W +: WORD_W] <= prev_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= (act_ff == ACT_READ) ? cur_q : '0;
         rsp_done_ff <= (act_ff == ACT_FRAME);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_frame_done = rsp_done_ff;

   // Addresses on the current and previous maps.
   assign ld_row       = cmd.frame_row - ROW_W'(1) + ROW_W'(cmd.ld_rowoff);
   assign cur_rd_en    = cmd.ld_issue | cmd.rmw_rd | cmd.rd_rd;
   assign cur_rd_addr  = cmd.ld_issue ? {ld_row, cmd.word}
                                      : {row_ff, col_ff[COL_W-1:LANE_SEL_W]};
   assign prev_rd_en   = cmd.ld_issue && (cmd.ld_rowoff == '0);
   assign prev_rd_addr = {cmd.frame_row, cmd.word};
   assign cur_wr_en    = cmd.rmw_wr;
   assign cur_wr_addr  = {row_ff, col_ff[COL_W-1:LANE_SEL_W]};
   assign prev_wr_en   = cmd.calc_wr;
   assign prev_wr_addr = {cmd.frame_row, cmd.word};

   // Byte merge for add and set.
   always_comb begin
      old_byte    = cur_q[col_ff[LANE_SEL_W-1:0]*CELL_W +: CELL_W];
      new_byte    = (act_ff == ACT_ADD) ? old_byte + amt_ff : amt_ff;
      cur_wr_data = cur_q;
      cur_wr_data[col_ff[LANE_SEL_W-1:0]*CELL_W +: CELL_W] = new_byte;
   end

   // Eight stencil lanes over one word of the row; border columns copy the previous map's value.
   always_comb begin
      prev_wr_data = '0;
      lane_c = '0;
      lane_l = '0;
      lane_r = '0;
      lane_sum = '0;
      lane_old = '0;
      for (int k = 0; k < LANE_CNT; k++) begin
         lane_c   = {cmd.word, LANE_SEL_W'(k)};
         lane_l   = lane_c - COL_W'(1);
         lane_r   = lane_c + COL_W'(1);
         lane_old = prev_row_ff[lane_c*CELL_W +: CELL_W];
         lane_sum = SUM_W'(win_ff[0][lane_l*CELL_W +: CELL_W])
                  + SUM_W'(win_ff[0][lane_c*CELL_W +: CELL_W])
                  + SUM_W'(win_ff[0][lane_r*CELL_W +: CELL_W])
                  + SUM_W'(win_ff[1][lane_l*CELL_W +: CELL_W])
                  + SUM_W'(win_ff[1][lane_r*CELL_W +: CELL_W])
                  + SUM_W'(win_ff[2][lane_l*CELL_W +: CELL_W])
                  + SUM_W'(win_ff[2][lane_c*CELL_W +: CELL_W])
                  + SUM_W'(win_ff[2][lane_r*CELL_W +: CELL_W]);
         if (lane_c != '0 && lane_c != COL_W'(GRID_SIDE - 1)) begin
            prev_wr_data[k*CELL_W +: CELL_W] = cell_next(lane_sum, lane_old, damp_ff);
         end else begin
            prev_wr_data[k*CELL_W +: CELL_W] = lane_old;
         end
      end
   end

   // Steer current and previous ports onto maps a and b.
   assign a_wr_en   = cmd.clear_wr | (cur_is_b_ff ? prev_wr_en : cur_wr_en);
   assign a_wr_addr = cmd.clear_wr ? cmd.clear_addr
                    : (cur_is_b_ff ? prev_wr_addr : cur_wr_addr);
   assign a_wr_data = cmd.clear_wr ? '0 : (cur_is_b_ff ? prev_wr_data : cur_wr_data);
   assign b_wr_en   = cmd.clear_wr | (cur_is_b_ff ? cur_wr_en : prev_wr_en);
   assign b_wr_addr = cmd.clear_wr ? cmd.clear_addr
                    : (cur_is_b_ff ? cur_wr_addr : prev_wr_addr);
   assign b_wr_data = cmd.clear_wr ? '0 : (cur_is_b_ff ? cur_wr_data : prev_wr_data);
   assign a_rd_en   = cur_is_b_ff ? prev_rd_en : cur_rd_en;
   assign a_rd_addr = cur_is_b_ff ? prev_rd_addr : cur_rd_addr;
   assign b_rd_en   = cur_is_b_ff ? cur_rd_en : prev_rd_en;
   assign b_rd_addr = cur_is_b_ff ? cur_rd_addr : prev_rd_addr;
   assign cur_q     = cur_is_b_ff ? b_q : a_q;
   assign prev_q    = cur_is_b_ff ? a_q : b_q;

   wrs_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_q)
   );

   wrs_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_q)
   );

endmodule
